FILE: design/frm_pkg.sv
`default_nettype none
package frm_pkg;

  localparam int unsigned WINDOW    = 60;
  localparam int unsigned PERIOD_W  = 24;
  localparam int unsigned SUM_W     = 30;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned FPS_W     = 26;
  localparam int unsigned NUM_W     = 31;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned DIV_STEPS = NUM_W;

  localparam logic [COUNT_W-1:0] WINDOW_C  = COUNT_W'(WINDOW);
  localparam logic [NUM_W-1:0]   SCALE_C   = NUM_W'(2000000);
  localparam logic [FPS_W-1:0]   FPS_MAX_C = FPS_W'(60000000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } frm_state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic prep;
    logic step;
    logic emit;
  } frm_cmd_t;

  typedef struct packed {
    logic div_last;
  } frm_stat_t;

endpackage
`default_nettype wire

FILE: design/frm_dp.sv
`default_nettype none
module frm_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [frm_pkg::PERIOD_W-1:0]     in_frame_period_us,
  input  frm_pkg::frm_cmd_t                cmd,
  output frm_pkg::frm_stat_t               stat,
  output logic [frm_pkg::FPS_W-1:0]        out_frames_per_second,
  output logic [frm_pkg::COUNT_W-1:0]      out_samples_in_window
);

  logic [frm_pkg::PERIOD_W-1:0] ring_mem [0:frm_pkg::WINDOW-1];
  logic [frm_pkg::PERIOD_W-1:0] rd_data_r;
  logic [frm_pkg::PERIOD_W-1:0] period_r;
  logic [frm_pkg::COUNT_W-1:0]  slot_r, slot_nxt;
  logic [frm_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [frm_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [frm_pkg::PERIOD_W-1:0] old_period;
  logic [frm_pkg::NUM_W-1:0]    den_r;
  logic [frm_pkg::NUM_W-1:0]    quo_r, quo_nxt;
  logic [frm_pkg::NUM_W-1:0]    rem_r, rem_nxt;
  logic [frm_pkg::NUM_W:0]      rem_shift;
  logic [frm_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         zero_r;
  logic [frm_pkg::FPS_W-1:0]    fps_r;
  logic [frm_pkg::COUNT_W-1:0]  cnt_out_r;

  // slot has never been written until the ring has filled once
  assign old_period = (count_r == frm_pkg::WINDOW_C) ? rd_data_r : '0;

  always_comb begin
    sum_nxt   = sum_r - frm_pkg::SUM_W'(old_period) + frm_pkg::SUM_W'(period_r);
    slot_nxt  = (slot_r == frm_pkg::WINDOW_C - 1'b1) ? '0 : slot_r + 1'b1;
    count_nxt = (count_r == frm_pkg::WINDOW_C) ? count_r : count_r + 1'b1;
  end

  // restoring divide, one quotient bit per step
  always_comb begin
    rem_shift = {rem_r, quo_r[frm_pkg::NUM_W-1]};
    if (rem_shift >= {1'b0, den_r}) begin
      rem_nxt = frm_pkg::NUM_W'(rem_shift - {1'b0, den_r});
      quo_nxt = {quo_r[frm_pkg::NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_shift[frm_pkg::NUM_W-1:0];
      quo_nxt = {quo_r[frm_pkg::NUM_W-2:0], 1'b0};
    end
    step_nxt = step_r + 1'b1;
  end

  assign stat.div_last = (step_r == frm_pkg::STEP_W'(frm_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data_r <= ring_mem[slot_r];
      period_r  <= in_frame_period_us;
    end
    if (cmd.update) begin
      ring_mem[slot_r] <= period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.update) begin
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      // numerator 2e6*count + sum, denominator 2*sum: rounds half up
      quo_r  <= frm_pkg::NUM_W'(frm_pkg::SCALE_C * frm_pkg::NUM_W'(count_r))
                + frm_pkg::NUM_W'(sum_r);
      den_r  <= {sum_r, 1'b0};
      rem_r  <= '0;
      step_r <= '0;
      zero_r <= (sum_r == '0);
    end else if (cmd.step) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_nxt;
    end
    if (cmd.emit) begin
      fps_r     <= zero_r ? '0 : quo_r[frm_pkg::FPS_W-1:0];
      cnt_out_r <= count_r;
    end
  end

  assign out_frames_per_second = fps_r;
  assign out_samples_in_window = cnt_out_r;

endmodule
`default_nettype wire

FILE: design/frm_ctrl.sv
`default_nettype none
module frm_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  frm_pkg::frm_stat_t  stat,
  output frm_pkg::frm_cmd_t   cmd
);

  frm_pkg::frm_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      frm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = frm_pkg::ST_READ;
        end
      end
      frm_pkg::ST_READ: begin
        state_nxt = frm_pkg::ST_UPDATE;
      end
      frm_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = frm_pkg::ST_PREP;
      end
      frm_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = frm_pkg::ST_DIV;
      end
      frm_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_nxt = frm_pkg::ST_EMIT;
        end
      end
      frm_pkg::ST_EMIT: begin
        // wait here only while the previous result is still held
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = frm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = frm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: design/frame_rate_moving_average_meter.sv
`default_nettype none
// channel  direction  fields                                        handshake
// in_      input      frame_period_us[23:0]                          in_valid / in_stall
// out_     output     frames_per_second[25:0], samples_in_window[5:0] out_valid / out_stall
//
// Each word goes from acceptance to result through ring read, sum update,
// operand set-up, then a 31-step restoring divider that yields one quotient bit a cycle.
// The divider sets the rate; the next word is taken once the result sits in the
// output register, which holds it under out_stall.
// Synchronous active-low reset empties the window; the fill count masks ring entries
// not yet written, so the ring needs no clearing pass.
module frame_rate_moving_average_meter (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [frm_pkg::PERIOD_W-1:0]     in_frame_period_us,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [frm_pkg::FPS_W-1:0]        out_frames_per_second,
  output logic [frm_pkg::COUNT_W-1:0]      out_samples_in_window
);

  frm_pkg::frm_cmd_t  cmd;
  frm_pkg::frm_stat_t stat;

  frm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  frm_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_frame_period_us    (in_frame_period_us),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_frames_per_second (out_frames_per_second),
    .out_samples_in_window (out_samples_in_window)
  );

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.update, cmd.prep, cmd.step, cmd.emit}))
    else $error("more than one datapath command at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the word was processed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_samples_in_window != '0 &&
                   out_samples_in_window <= frm_pkg::WINDOW_C))
    else $error("window count out of range");

  a_fps_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frames_per_second <= frm_pkg::FPS_MAX_C))
    else $error("frame rate beyond largest possible value");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwritten while still held");

endmodule
`default_nettype wire
